>>> sv/dtfg_pkg.sv
`timescale 1ns / 1ps
package dtfg_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest unsigned value (1233/4096 is just below log10 2).
  localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int RW    = $clog2(NDIG + 1);

  localparam logic [1:0] R3_INIT = 2'(NDIG % 3);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SIGNED_MODE = 1'b0;

endpackage

>>> sv/decimal_text_formatter_grouped_top.sv
`timescale 1ns / 1ps
// A word is converted bit-serially (shift-add-3), leading zero digits are then dropped one per cycle
// (up to 9), and the EMIT state then loads the characters into the output register.
// One character is loaded per cycle while out_stall does not hold the output; in_stall stays
// high until the last digit is loaded, so a new value is accepted only after that.
// Reset (synchronous, active high) clears the control state, out_valid and signed_mode.
module decimal_text_formatter_grouped_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtfg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dtfg_pkg::VALUE_WIDTH-1:0]    value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_char,
  output logic                                last_char
);
  import dtfg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam int BW = 4 * NDIG;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic [RW-1:0]          r;
  logic [1:0]             r3;
  logic [1:0]             r3_next;
  logic                   neg_pend;
  logic                   comma_pend;
  logic                   signed_mode;
  logic [3:0]             top_digit;
  logic                   in_accept;
  logic                   out_load;
  logic                   is_neg;
  logic [VALUE_WIDTH-1:0] mag;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIGNED_MODE) ? {31'd0, signed_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SIGNED_MODE) begin
      signed_mode <= pwdata[0];
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign is_neg = signed_mode && value[VALUE_WIDTH-1];
  assign mag    = is_neg ? (~value + 1'b1) : value;

  // Add 3 to every digit of 5 or more before the shift (double dabble).
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  assign top_digit = bcd[BW-1 -: 4];
  assign r3_next   = (r3 == 2'd0) ? 2'd2 : r3 - 2'd1;
  assign out_load  = (state == S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      neg_pend   <= 1'b0;
      comma_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state      <= S_CONV;
            neg_pend   <= is_neg;
            comma_pend <= 1'b0;
          end
        end
        S_CONV: begin
          if (cnt == CNT_W'(1)) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (!(top_digit == 4'd0 && r > RW'(1))) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (neg_pend) begin
              neg_pend <= 1'b0;
            end else if (comma_pend) begin
              comma_pend <= 1'b0;
            end else begin
              comma_pend <= (r3_next == 2'd0);
              if (r == RW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          bin <= mag;
          bcd <= '0;
          cnt <= CNT_W'(VALUE_WIDTH);
          r   <= RW'(NDIG);
          r3  <= R3_INIT;
        end
      end
      S_CONV: begin
        bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
        bcd <= {bcd_adj[BW-2:0], bin[VALUE_WIDTH-1]};
        cnt <= cnt - CNT_W'(1);
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && r > RW'(1)) begin
          bcd <= {bcd[BW-5:0], 4'd0};
          r   <= r - RW'(1);
          r3  <= r3_next;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (neg_pend) begin
            out_char  <= CHAR_MINUS;
            last_char <= 1'b0;
          end else if (comma_pend) begin
            out_char  <= CHAR_COMMA;
            last_char <= 1'b0;
          end else begin
            out_char  <= CHAR_ZERO + {4'd0, top_digit};
            last_char <= (r == RW'(1));
            bcd       <= {bcd[BW-5:0], 4'd0};
            r         <= r - RW'(1);
            r3        <= r3_next;
          end
        end
      end
      default: ;
    endcase
  end

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV |-> cnt != '0)
    else $error("conversion running with an exhausted bit count");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP || state == S_EMIT) |-> (r != '0 && r <= RW'(NDIG)))
    else $error("digit count out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_CONV)
    else $error("accepted word did not start a conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && !neg_pend && !comma_pend && r == RW'(1)) |=> (last_char && state == S_IDLE))
    else $error("final digit not marked last");

  a_idle_next: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> (state == S_IDLE || state == S_CONV))
    else $error("left idle without a word");

endmodule
